FILE: rtl/rcw_pkg.sv
// ---------------------------------------------------------------------------
// rcw_pkg
// Shared types and constants of the Reno congestion window sender.
// ---------------------------------------------------------------------------
package rcw_pkg;

   // Q8.8 constants, then the dup ack limit and the send limit
   localparam logic [15:0] ONE_Q88       = 16'h0100;
   localparam logic [15:0] DUP_BUMP_Q88  = 16'h0300;
   localparam logic [15:0] THR_RESET_Q88 = 16'h4000;
   localparam logic [1:0]  DUP_LIMIT     = 2'd3;
   localparam int          MAX_SENDS     = 32;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_TOTAL_PACKETS     = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_WINDOW    = 2'd1;
   localparam logic [1:0] CSR_INITIAL_THRESHOLD = 2'd2;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_ACK     = 2'd1,
      ACT_TIMEOUT = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_SLOW  = 2'd0,
      PH_AVOID = 2'd1,
      PH_RECOV = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ACK_EVAL,
      ST_DIV,
      ST_PROMOTE,
      ST_WALK_INIT,
      ST_WALK_CHK,
      ST_WALK_EVAL,
      ST_ADV_CHK,
      ST_ADV_EVAL,
      ST_FINAL
   } state_type;

   // divider handshake between sequencer and reciprocal unit
   typedef struct packed {
      logic        start;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quotient;
   } div_rsp_type;

   // saturate a grown window at the cap
   function automatic logic [15:0] sat_win(input logic [17:0] w, input logic [15:0] cap);
      logic [15:0] r;
      r = (w > {2'b00, cap}) ? cap : w[15:0];
      return r;
   endfunction

endpackage

FILE: rtl/rcw_ram.sv
// ---------------------------------------------------------------------------
// rcw_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module rcw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, old data on a same-cycle write
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/rcw_div.sv
// ---------------------------------------------------------------------------
// rcw_div
// Bit-serial restoring divider for 65536 / window (Q8.8 reciprocal step).
// ---------------------------------------------------------------------------
module rcw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rcw_pkg::div_req_type req,
   output rcw_pkg::div_rsp_type rsp
);
   import rcw_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dvd_ff, dvd_in;
   logic [16:0] quo_ff, quo_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;

   // one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff[15:0], dvd_ff[16]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         rem_in  = 17'd0;
         dvd_in  = 17'h10000;
         quo_in  = 17'd0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[15:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[15:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

FILE: rtl/reno_congestion_window_sender.sv
// ---------------------------------------------------------------------------
// reno_congestion_window_sender
// Reno congestion window sender with selective ack marks in a ring RAM.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one event (start, ack, timeout). req_ready is high
//    only while the sequencer is idle; one event is handled at a time.
//  - rsp_ channel returns one transaction per packet send, or one status
//    transaction when the event sends nothing; rsp_last marks the final one.
//  - csr_ writes take effect at once, with no handshake; write them while
//    the block is idle.
//  - Each event passes a decode step; a new ack in congestion avoidance then
//    waits on the reciprocal divider; then come a send walk over the sequence
//    numbers it examines and an advance of the send base over acked slots.
//    The single read port of the ack ring sets the walk rate.
//  - Reset: registers load their defaults and a clearing pass writes every
//    ack ring entry to zero, with req_ready low.
//  - A stalled receiver holds the result register; the sequencer waits
//    before each further result until the register frees up.
// ---------------------------------------------------------------------------
module reno_congestion_window_sender #(
   parameter int WINDOW    = 32,
   parameter int MAP_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_action,
   input  logic [31:0]             req_ack_seq,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_send_valid,
   output logic [31:0]             rsp_send_seq,
   output logic                    rsp_is_fin,
   output logic                    rsp_transfer_done,
   output logic [1:0]              rsp_phase_now,
   output logic                    rsp_ack_out_of_range,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [1:0]              csr_addr,
   input  logic [31:0]             csr_wdata
);
   import rcw_pkg::*;

   localparam int          AW      = $clog2(MAP_DEPTH);
   localparam int          CW      = $clog2(MAP_DEPTH + 1);
   localparam logic [15:0] CAP_Q88 = 16'(WINDOW * 256);

   // state registers
   state_type   state_ff, state_in;
   logic [31:0] total_ff, total_in;
   logic [5:0]  tw_ff, tw_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] win_ff, win_in;
   logic [15:0] thr_ff, thr_in;
   logic [1:0]  dup_ff, dup_in;
   logic [32:0] base_ff, base_in;
   logic [AW-1:0] bslot_ff, bslot_in;
   logic [31:0] lsent_ff, lsent_in;
   logic        fin_ff, fin_in;
   // per-event registers
   action_type  act_ff, act_in;
   logic [31:0] ack_ff, ack_in;
   logic        oor_ff, oor_in;
   logic        retx_ff, retx_in;
   logic        walk_ff, walk_in;
   logic        adv_ff, adv_in;
   logic        pend_ff, pend_in;
   logic [31:0] pseq_ff, pseq_in;
   logic [32:0] nxt_ff, nxt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [CW-1:0] acnt_ff, acnt_in;
   // result register
   logic        rv_ff, rv_in;
   logic        rsv_ff, rsv_in;
   logic [31:0] rseq_ff, rseq_in;
   logic        rdone_ff, rdone_in;
   phase_type   rph_ff, rph_in;
   logic        roor_ff, roor_in;
   logic        rlast_ff, rlast_in;

   // ring RAM and divider hookup
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic          ram_rdata;
   div_req_type   dreq;
   div_rsp_type   drsp;

   // helpers
   logic [32:0] ack_ext;
   logic [32:0] diff_sel;
   logic [AW:0] slot_sum;
   logic [AW-1:0] slot;
   logic        out_free;
   logic        emit;
   logic        e_sv;
   logic [31:0] e_seq;
   logic        e_last;
   logic [32:0] walk_diff;
   logic        walk_go;
   logic [32:0] start_nxt;
   // dup ack outcome
   logic [15:0] d_win, d_thr;
   phase_type   d_phase;
   logic [1:0]  d_dup, d_cnt;
   logic        d_walk, d_retx;

   rcw_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rcw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign ack_ext  = {1'b0, ack_ff};
   assign out_free = !rv_ff || rsp_ready;

   // ring slot of a sequence at distance diff from the send base
   always_comb begin
      if (state_ff == ST_DECODE || state_ff == ST_ACK_EVAL) begin
         diff_sel = ack_ext - base_ff;
      end else if (state_ff == ST_WALK_CHK || state_ff == ST_WALK_EVAL) begin
         diff_sel = nxt_ff - base_ff;
      end else begin
         diff_sel = 33'd0;
      end
      slot_sum = {1'b0, bslot_ff} + {1'b0, diff_sel[AW-1:0]};
      if (slot_sum >= (AW+1)'(MAP_DEPTH)) begin
         slot_sum = slot_sum - (AW+1)'(MAP_DEPTH);
      end
      slot = slot_sum[AW-1:0];
   end

   assign ram_raddr = slot;

   // send walk bounds
   assign walk_diff = nxt_ff - base_ff;
   assign walk_go   = (nxt_ff <= {1'b0, total_ff}) &&
                      (walk_diff[32:8] == 25'd0) &&
                      ({walk_diff[7:0], 8'h00} < win_ff) &&
                      (walk_diff < 33'(MAP_DEPTH)) &&
                      (cnt_ff < 6'(MAX_SENDS));
   assign start_nxt = (!retx_ff && ({1'b0, lsent_ff} + 33'd1 > base_ff)) ?
                      {1'b0, lsent_ff} + 33'd1 : base_ff;

   // duplicate ack outcome
   always_comb begin
      d_win   = win_ff;
      d_thr   = thr_ff;
      d_phase = phase_ff;
      d_dup   = dup_ff;
      d_walk  = 1'b0;
      d_retx  = 1'b0;
      d_cnt   = (dup_ff < DUP_LIMIT) ? dup_ff + 2'd1 : dup_ff;
      if (phase_ff == PH_RECOV) begin
         d_win  = sat_win({2'b00, win_ff} + {2'b00, ONE_Q88}, CAP_Q88);
         d_walk = 1'b1;
      end else begin
         d_dup = d_cnt;
         if (d_cnt == DUP_LIMIT) begin
            d_thr   = {1'b0, win_ff[15:1]};
            d_win   = sat_win({3'b000, win_ff[15:1]} + {2'b00, DUP_BUMP_Q88}, CAP_Q88);
            d_phase = PH_RECOV;
            d_walk  = 1'b1;
            d_retx  = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      tw_in    = tw_ff;
      phase_in = phase_ff;
      win_in   = win_ff;
      thr_in   = thr_ff;
      dup_in   = dup_ff;
      base_in  = base_ff;
      bslot_in = bslot_ff;
      lsent_in = lsent_ff;
      fin_in   = fin_ff;
      act_in   = act_ff;
      ack_in   = ack_ff;
      oor_in   = oor_ff;
      retx_in  = retx_ff;
      walk_in  = walk_ff;
      adv_in   = adv_ff;
      pend_in  = pend_ff;
      pseq_in  = pseq_ff;
      nxt_in   = nxt_ff;
      cnt_in   = cnt_ff;
      acnt_in  = acnt_ff;
      ram_we    = 1'b0;
      ram_waddr = bslot_ff;
      ram_wdata = 1'b0;
      dreq.start   = 1'b0;
      dreq.divisor = win_ff;
      emit   = 1'b0;
      e_sv   = 1'b0;
      e_seq  = 32'd0;
      e_last = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = acnt_ff[AW-1:0];
            acnt_in   = acnt_ff + CW'(1);
            if (acnt_ff == CW'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in   = action_type'(req_action);
               ack_in   = req_ack_seq;
               oor_in   = 1'b0;
               retx_in  = 1'b0;
               walk_in  = 1'b0;
               adv_in   = 1'b0;
               pend_in  = 1'b0;
               cnt_in   = 6'd0;
               acnt_in  = '0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_PROMOTE;
            if (fin_ff) begin
               state_in = ST_FINAL;
            end else begin
               case (act_ff)
                  ACT_START: begin
                     walk_in = 1'b1;
                  end
                  ACT_TIMEOUT: begin
                     thr_in   = {1'b0, win_ff[15:1]};
                     win_in   = (phase_ff == PH_RECOV) ? sat_win({2'b00, ONE_Q88}, CAP_Q88)
                                : sat_win({4'b0000, tw_ff, 8'h00}, CAP_Q88);
                     dup_in   = 2'd0;
                     phase_in = PH_SLOW;
                     walk_in  = 1'b1;
                     retx_in  = 1'b1;
                  end
                  ACT_ACK: begin
                     if (ack_ff == 32'd0) begin
                        fin_in = 1'b1;
                     end else if (ack_ff > total_ff ||
                                  (ack_ext >= base_ff &&
                                   ack_ext - base_ff >= 33'(MAP_DEPTH))) begin
                        oor_in = 1'b1;
                     end else if (ack_ext < base_ff) begin
                        win_in   = d_win;
                        thr_in   = d_thr;
                        phase_in = d_phase;
                        dup_in   = d_dup;
                        walk_in  = d_walk;
                        retx_in  = d_retx;
                        adv_in   = 1'b1;
                     end else begin
                        state_in = ST_ACK_EVAL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ACK_EVAL: begin
            adv_in   = 1'b1;
            state_in = ST_PROMOTE;
            if (ram_rdata) begin
               win_in   = d_win;
               thr_in   = d_thr;
               phase_in = d_phase;
               dup_in   = d_dup;
               walk_in  = d_walk;
               retx_in  = d_retx;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = slot;
               ram_wdata = 1'b1;
               dup_in    = 2'd0;
               walk_in   = 1'b1;
               case (phase_ff)
                  PH_SLOW: begin
                     win_in = sat_win({2'b00, win_ff} + {2'b00, ONE_Q88}, CAP_Q88);
                  end
                  PH_AVOID: begin
                     if (win_ff == 16'd0) begin
                        win_in = CAP_Q88;
                     end else begin
                        dreq.start = 1'b1;
                        state_in   = ST_DIV;
                     end
                  end
                  default: begin
                     win_in   = sat_win({2'b00, thr_ff}, CAP_Q88);
                     phase_in = PH_AVOID;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               win_in   = sat_win({2'b00, win_ff} + {1'b0, drsp.quotient}, CAP_Q88);
               state_in = ST_PROMOTE;
            end
         end
         ST_PROMOTE: begin
            if (phase_ff == PH_SLOW && win_ff >= thr_ff) begin
               phase_in = PH_AVOID;
            end
            if (walk_ff) begin
               state_in = ST_WALK_INIT;
            end else if (adv_ff) begin
               state_in = ST_ADV_CHK;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_WALK_INIT: begin
            if (base_ff > {1'b0, total_ff}) begin
               // everything acked: a FIN goes out
               pend_in  = 1'b1;
               pseq_in  = 32'd0;
               state_in = adv_ff ? ST_ADV_CHK : ST_FINAL;
            end else begin
               nxt_in   = start_nxt;
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (walk_go) begin
               state_in = ST_WALK_EVAL;
            end else begin
               lsent_in = 32'(nxt_ff - 33'd1);
               state_in = adv_ff ? ST_ADV_CHK : ST_FINAL;
            end
         end
         ST_WALK_EVAL: begin
            if (ram_rdata) begin
               nxt_in   = nxt_ff + 33'd1;
               state_in = ST_WALK_CHK;
            end else if (!pend_ff || out_free) begin
               // previous send goes out, this one waits for its last flag
               emit     = pend_ff;
               e_sv     = 1'b1;
               e_seq    = pseq_ff;
               pend_in  = 1'b1;
               pseq_in  = nxt_ff[31:0];
               cnt_in   = cnt_ff + 6'd1;
               nxt_in   = nxt_ff + 33'd1;
               state_in = ST_WALK_CHK;
            end
         end
         ST_ADV_CHK: begin
            if (acnt_ff == CW'(MAP_DEPTH) || base_ff > {1'b0, total_ff}) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_ADV_EVAL;
            end
         end
         ST_ADV_EVAL: begin
            if (ram_rdata) begin
               ram_we    = 1'b1;
               ram_waddr = bslot_ff;
               ram_wdata = 1'b0;
               base_in   = base_ff + 33'd1;
               bslot_in  = (bslot_ff == AW'(MAP_DEPTH - 1)) ? '0 : bslot_ff + AW'(1);
               acnt_in   = acnt_ff + CW'(1);
               state_in  = ST_ADV_CHK;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               emit     = 1'b1;
               e_sv     = pend_ff;
               e_seq    = pend_ff ? pseq_ff : 32'd0;
               e_last   = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration writes
      if (csr_we) begin
         case (csr_addr)
            CSR_TOTAL_PACKETS: begin
               total_in = csr_wdata;
            end
            CSR_TIMEOUT_WINDOW: begin
               tw_in = csr_wdata[5:0];
            end
            CSR_INITIAL_THRESHOLD: begin
               thr_in = {1'b0, csr_wdata[6:0], 8'h00};
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rv_in    = rv_ff;
      rsv_in   = rsv_ff;
      rseq_in  = rseq_ff;
      rdone_in = rdone_ff;
      rph_in   = rph_ff;
      roor_in  = roor_ff;
      rlast_in = rlast_ff;
      if (emit) begin
         rv_in    = 1'b1;
         rsv_in   = e_sv;
         rseq_in  = e_seq;
         rdone_in = fin_ff;
         rph_in   = phase_ff;
         roor_in  = oor_ff;
         rlast_in = e_last;
      end else if (rsp_ready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         total_ff <= 32'd0;
         tw_ff    <= 6'd1;
         phase_ff <= PH_SLOW;
         win_ff   <= ONE_Q88;
         thr_ff   <= THR_RESET_Q88;
         dup_ff   <= 2'd0;
         base_ff  <= 33'd1;
         bslot_ff <= AW'(1 % MAP_DEPTH);
         lsent_ff <= 32'd0;
         fin_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         cnt_ff   <= 6'd0;
         acnt_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         tw_ff    <= tw_in;
         phase_ff <= phase_in;
         win_ff   <= win_in;
         thr_ff   <= thr_in;
         dup_ff   <= dup_in;
         base_ff  <= base_in;
         bslot_ff <= bslot_in;
         lsent_ff <= lsent_in;
         fin_ff   <= fin_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         acnt_ff  <= acnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      ack_ff   <= ack_in;
      oor_ff   <= oor_in;
      retx_ff  <= retx_in;
      walk_ff  <= walk_in;
      adv_ff   <= adv_in;
      pseq_ff  <= pseq_in;
      nxt_ff   <= nxt_in;
      rsv_ff   <= rsv_in;
      rseq_ff  <= rseq_in;
      rdone_ff <= rdone_in;
      rph_ff   <= rph_in;
      roor_ff  <= roor_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_send_valid       = rsv_ff;
   assign rsp_send_seq         = rseq_ff;
   assign rsp_is_fin           = rsv_ff && (rseq_ff == 32'd0);
   assign rsp_transfer_done    = rdone_ff;
   assign rsp_phase_now        = rph_ff;
   assign rsp_ack_out_of_range = roor_ff;
   assign rsp_last             = rlast_ff;

   // checks
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsv_ff |-> rlast_ff)
      else $error("status transaction without last flag");

   a_send_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'(MAX_SENDS))
      else $error("send count beyond limit");

   a_win_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |-> win_ff <= CAP_Q88)
      else $error("window above cap");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_ff)
      else $error("pending send left over at idle");
endmodule
